@@ rtl/pc128_pkg.sv @@
// Package for the Piccolo-128 encryption pipeline: sizes, S-box, round constants,
// the F function, the byte permutation and key schedule word selection.
// No dependencies.
package pc128_pkg;

	// Number of rounds, one pipeline cell each (legal range 1..31).
	localparam int unsigned ROUNDS = 31;
	// Size of the round constant table.
	localparam int unsigned MAX_ROUNDS = 31;

	localparam int unsigned BLOCK_W = 64;
	localparam int unsigned KEY_W = 64;
	localparam int unsigned WORD_W = 16;

	// Configuration register indexes.
	localparam logic REG_KEY_HIGH = 1'b0;
	localparam logic REG_KEY_LOW = 1'b1;

	// Reduction polynomial x^4+x+1.
	localparam logic [4:0] GF_POLY = 5'h13;

	localparam logic [3:0] SBOX [16] = '{
		4'hE, 4'h4, 4'hB, 4'h2, 4'h3, 4'h8, 4'h0, 4'h9,
		4'h1, 4'hA, 4'h7, 4'hF, 4'h6, 4'hC, 4'h5, 4'hD
	};

	localparam logic [31:0] ROUND_CONST [MAX_ROUNDS] = '{
		32'h6d45ad8a, 32'h7543a189, 32'h7d41a588, 32'h454fb98f, 32'h4d4dbd8e,
		32'h554bb18d, 32'h5d49b58c, 32'h25578983, 32'h2d558d82, 32'h35538181,
		32'h3d518580, 32'h055f9987, 32'h0d5d9d86, 32'h155b9185, 32'h1d599584,
		32'he567e99b, 32'hed65ed9a, 32'hf563e199, 32'hfd61e598, 32'hc56ff99f,
		32'hcd6dfd9e, 32'hd56bf19d, 32'hdd69f59c, 32'ha577c993, 32'had75cd92,
		32'hb573c191, 32'hbd71c590, 32'h857fd997, 32'h8d7ddd96, 32'h957bd195,
		32'h9d79d594
	};

	// Multiply by x in GF(16).
	function automatic logic [3:0] gf_dbl(input logic [3:0] a);
		return {a[2:0], 1'b0} ^ (a[3] ? GF_POLY[3:0] : 4'h0);
	endfunction

	// Multiply by x+1 in GF(16).
	function automatic logic [3:0] gf_tri(input logic [3:0] a);
		return gf_dbl(a) ^ a;
	endfunction

	// F function: S-box layer, MDS diffusion, S-box layer.
	function automatic logic [15:0] f_func(input logic [15:0] v);
		logic [3:0] a0, a1, a2, a3;
		logic [3:0] b0, b1, b2, b3;
		a0 = SBOX[v[15:12]];
		a1 = SBOX[v[11:8]];
		a2 = SBOX[v[7:4]];
		a3 = SBOX[v[3:0]];
		b0 = gf_dbl(a0) ^ gf_tri(a1) ^ a2 ^ a3;
		b1 = a0 ^ gf_dbl(a1) ^ gf_tri(a2) ^ a3;
		b2 = a0 ^ a1 ^ gf_dbl(a2) ^ gf_tri(a3);
		b3 = gf_tri(a0) ^ a1 ^ a2 ^ gf_dbl(a3);
		return {SBOX[b0], SBOX[b1], SBOX[b2], SBOX[b3]};
	endfunction

	// Byte permutation (x0..x7) -> (x2,x7,x4,x1,x6,x3,x0,x5), byte 0 on top.
	function automatic logic [63:0] byte_perm(input logic [63:0] s);
		return {s[47:40], s[7:0], s[31:24], s[55:48],
			s[15:8], s[39:32], s[63:56], s[23:16]};
	endfunction

	// Which user key word feeds round key number i. Evaluated at elaboration;
	// the key words are reordered every eight round keys.
	function automatic logic [2:0] rk_word(input int unsigned i);
		logic [2:0] idx [8];
		logic [2:0] tmp [8];
		int unsigned k;
		int unsigned j;
		for (j = 0; j < 8; j++) begin
			idx[j] = 3'(j);
		end
		for (k = 0; k <= i; k++) begin
			if (((k + 2) & 7) == 0) begin
				tmp[0] = idx[2]; tmp[1] = idx[1]; tmp[2] = idx[6]; tmp[3] = idx[7];
				tmp[4] = idx[0]; tmp[5] = idx[3]; tmp[6] = idx[4]; tmp[7] = idx[5];
				idx = tmp;
			end
		end
		return idx[3'((i + 2) & 7)];
	endfunction

endpackage

@@ rtl/pc128_round_cell.sv @@
// One Piccolo-128 round cell: two F function branches and the stage register.
// Depends on pc128_pkg.
module pc128_round_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [pc128_pkg::BLOCK_W-1:0] in_data,
	input  logic [pc128_pkg::WORD_W-1:0]  rk_even,
	input  logic [pc128_pkg::WORD_W-1:0]  rk_odd,
	output logic                          out_valid,
	output logic [pc128_pkg::BLOCK_W-1:0] out_data
);
	import pc128_pkg::*;

	logic [WORD_W-1:0] x1_next;
	logic [WORD_W-1:0] x3_next;
	logic [BLOCK_W-1:0] data_q;
	logic valid_q;

	// Feistel update of branches one and three.
	assign x1_next = in_data[47:32] ^ f_func(in_data[63:48]) ^ rk_even;
	assign x3_next = in_data[15:0] ^ f_func(in_data[31:16]) ^ rk_odd;

	// Stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	// Stage data.
	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= {in_data[63:48], x1_next, in_data[31:16], x3_next};
		end
	end

	assign out_valid = valid_q;
	assign out_data = data_q;

endmodule

@@ rtl/piccolo128_block_encrypt.sv @@
// Top level of the Piccolo-128 encryption pipeline: key registers, whitening,
// key schedule wiring and the chain of round cells. Depends on pc128_pkg, pc128_round_cell.
//
//  Channel   Signals                          Direction
//  input     in_valid, in_ready, plaintext    into the block
//  output    out_valid, out_ready, ciphertext out of the block
//  config    wr_en, wr_index, wr_data         into the block, write only
//
// One block is accepted per cycle while in_ready is high; one round per cell in the chain,
// so each result passes through every cell register in turn before it shows on
// out_valid, and it stays there until out_ready takes it.
// All cells advance together; the chain holds whenever the last cell has a
// result that is not taken, and in_ready is low then.
// Reset clears the valid flags of all cells and the key registers.
module piccolo128_block_encrypt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [pc128_pkg::BLOCK_W-1:0] plaintext,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pc128_pkg::BLOCK_W-1:0] ciphertext,
	input  logic                          wr_en,
	input  logic                          wr_index,
	input  logic [pc128_pkg::KEY_W-1:0]   wr_data
);
	import pc128_pkg::*;

	logic [KEY_W-1:0] key_high_q;
	logic [KEY_W-1:0] key_low_q;
	logic [WORD_W-1:0] key_word [8];
	logic [WORD_W-1:0] wk0, wk1, wk2, wk3;
	logic [WORD_W-1:0] rk_even [ROUNDS];
	logic [WORD_W-1:0] rk_odd [ROUNDS];
	logic [BLOCK_W-1:0] cell_in [ROUNDS];
	logic [BLOCK_W-1:0] cell_out [ROUNDS];
	logic cell_in_valid [ROUNDS];
	logic cell_out_valid [ROUNDS];
	logic en;

	// Key registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_KEY_HIGH: key_high_q <= wr_data;
				REG_KEY_LOW:  key_low_q <= wr_data;
				default:      key_low_q <= key_low_q;
			endcase
		end
	end

	// Split the key into sixteen-bit words and form the whitening keys.
	always_comb begin
		key_word[0] = key_high_q[63:48];
		key_word[1] = key_high_q[47:32];
		key_word[2] = key_high_q[31:16];
		key_word[3] = key_high_q[15:0];
		key_word[4] = key_low_q[63:48];
		key_word[5] = key_low_q[47:32];
		key_word[6] = key_low_q[31:16];
		key_word[7] = key_low_q[15:0];
	end

	assign wk0 = {key_word[0][15:8], key_word[1][7:0]};
	assign wk1 = {key_word[1][15:8], key_word[0][7:0]};
	assign wk2 = {key_word[4][15:8], key_word[7][7:0]};
	assign wk3 = {key_word[7][15:8], key_word[4][7:0]};

	// The whole chain moves unless the finished result is stalled.
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	// Round keys, cell inputs and the chain of cells.
	for (genvar r = 0; r < ROUNDS; r++) begin : g_round
		localparam logic [2:0] W_EVEN = rk_word(2 * r);
		localparam logic [2:0] W_ODD = rk_word(2 * r + 1);

		assign rk_even[r] = key_word[W_EVEN] ^ ROUND_CONST[r][31:16];
		assign rk_odd[r] = key_word[W_ODD] ^ ROUND_CONST[r][15:0];

		if (r == 0) begin : g_first
			assign cell_in[r] = {plaintext[63:48] ^ wk0, plaintext[47:32],
				plaintext[31:16] ^ wk1, plaintext[15:0]};
			assign cell_in_valid[r] = in_valid;
		end else begin : g_next
			assign cell_in[r] = byte_perm(cell_out[r-1]);
			assign cell_in_valid[r] = cell_out_valid[r-1];
		end

		pc128_round_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (cell_in_valid[r]),
			.in_data   (cell_in[r]),
			.rk_even   (rk_even[r]),
			.rk_odd    (rk_odd[r]),
			.out_valid (cell_out_valid[r]),
			.out_data  (cell_out[r])
		);
	end

	// Final whitening; the last round has no byte permutation.
	assign out_valid = cell_out_valid[ROUNDS-1];
	assign ciphertext = {cell_out[ROUNDS-1][63:48] ^ wk2, cell_out[ROUNDS-1][47:32],
		cell_out[ROUNDS-1][31:16] ^ wk3, cell_out[ROUNDS-1][15:0]};

endmodule

@@ rtl/pc128_checker.sv @@
// Port-level checks for piccolo128_block_encrypt, attached with a bind statement.
// Depends on pc128_pkg and on the top level's port list.
module pc128_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [pc128_pkg::BLOCK_W-1:0] ciphertext,
	input logic                          wr_en
);
	import pc128_pkg::*;

	// No result is shown while reset is held.
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

	// The block takes a transaction exactly when its output side can move.
	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not follow the output side");

	// A stalled result stays and does not change.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(ciphertext))
		else $error("stalled result dropped or changed");

	// If no result, no input and no key write, a result follows only after in_ready.
	a_no_new_result: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !in_valid && !wr_en |=> !out_valid || $past(in_ready))
		else $error("result appeared without the chain moving");

endmodule

bind piccolo128_block_encrypt pc128_checker u_pc128_checker (.*);
